FILE: hdl/tbpa_pkg.sv
// Shared types and codes for the two-level bitmap page allocator.
package tbpa_pkg;

  typedef enum logic [2:0] {
    STAT_ALLOC    = 3'd0,
    STAT_NONE     = 3'd1,
    STAT_DEC      = 3'd2,
    STAT_REL      = 3'd3,
    STAT_NOTALLOC = 3'd4
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic {
    S_IDLE,
    S_MOD
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

FILE: hdl/tbpa_word_store.sv
// Free-page bitmap memory with its group summary bits and its fill pass after reset.
module tbpa_word_store
  import tbpa_pkg::*;
#(
  parameter int GROUPS = 64,
  parameter int GW     = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mem_ctl_t      ctl,
  input  logic [GW-1:0] rd_group,
  input  logic [GW-1:0] wr_group,
  input  logic [31:0]   wr_word,
  output logic [31:0]   rd_word,
  output logic          busy,
  output logic [GW-1:0] low_group,
  output logic          any_free
);

  logic [31:0]       mem [GROUPS];
  logic [31:0]       rd_word_r;
  logic [GROUPS-1:0] sum_r;
  logic              clr_r;
  logic [GW-1:0]     clr_idx_r;
  logic              mem_we;
  logic [GW-1:0]     mem_wa;
  logic [31:0]       mem_wd;

  assign mem_we = clr_r | ctl.wr_en;
  assign mem_wa = clr_r ? clr_idx_r : wr_group;
  assign mem_wd = clr_r ? '1 : wr_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (ctl.rd_en) begin
      rd_word_r <= mem[rd_group];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + GW'(1);
      if (clr_idx_r == GW'(GROUPS - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '1;
    end else if (ctl.wr_en) begin
      sum_r[wr_group] <= |wr_word;
    end
  end

  always_comb begin
    low_group = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (sum_r[i]) begin
        low_group = GW'(i);
      end
    end
  end

  assign any_free = |sum_r;
  assign rd_word  = rd_word_r;
  assign busy     = clr_r;

endmodule

FILE: hdl/tbpa_count_store.sv
// Per-page use count memory with a registered read port.
module tbpa_count_store
  import tbpa_pkg::*;
#(
  parameter int PAGES      = 2048,
  parameter int PW         = 11,
  parameter int COUNT_BITS = 8
) (
  input  logic                  clk,
  input  mem_ctl_t              ctl,
  input  logic [PW-1:0]         rd_page,
  input  logic [PW-1:0]         wr_page,
  input  logic [COUNT_BITS-1:0] wr_count,
  output logic [COUNT_BITS-1:0] rd_count
);

  logic [COUNT_BITS-1:0] mem [PAGES];
  logic [COUNT_BITS-1:0] rd_count_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_page] <= wr_count;
    end
    if (ctl.rd_en) begin
      rd_count_r <= mem[rd_page];
    end
  end

  assign rd_count = rd_count_r;

endmodule

FILE: hdl/two_level_bitmap_page_allocator.sv
// Top level of the two-level bitmap page allocator.
// A beat accepted in S_IDLE is worked in S_MOD; its result beat is registered when out_free allows.
// Bitmap read on accept, then modify and write back in S_MOD; input is taken only in S_IDLE.
// A result waiting on out_tready holds the write-back of the next beat.
// After reset the bitmap memory is filled with ones, one word a cycle for each of the PAGES/32
// groups, and in_tready stays low until the fill is done.
module two_level_bitmap_page_allocator
  import tbpa_pkg::*;
#(
  parameter int PAGES      = 2048,
  parameter int COUNT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // use_count_init[7:0], page_addr[18:8], zeros
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // page[10:0], status[13:11], free_count[25:14], zeros
);

  localparam int GROUPS = PAGES / 32;
  localparam int GW     = $clog2(GROUPS);
  localparam int PW     = $clog2(PAGES);
  localparam int CNTW   = $clog2(PAGES + 1);
  localparam logic [16:0] CMAX = (17'(1) << COUNT_BITS) - 17'(1);

  state_t                state_r, state_nxt;
  mem_ctl_t              wctl, cctl;
  logic                  busy, any_free;
  logic [GW-1:0]         low_group, rd_group;
  logic [31:0]           rd_word, wr_word;
  logic [COUNT_BITS-1:0] rd_count, wr_count;
  logic [PW-1:0]         in_idx, wr_page;

  logic                  accept, out_free, fire;
  logic                  mode_r, none_r, in_range_r;
  logic [7:0]            ucnt_r;
  logic [10:0]           addr_r;
  logic [GW-1:0]         grp_r;
  logic [PW-1:0]         addr_idx;

  logic [4:0]            low_bit;
  logic                  page_bit;
  logic [7:0]            ucnt_eff;
  logic [16:0]           ucnt_sat;
  status_t               status;
  logic [10:0]           page_out;
  logic                  cnt_dec, cnt_inc;
  logic [CNTW-1:0]       cnt_r;
  logic                  out_tvalid_r;
  logic [31:0]           out_tdata_r;

  tbpa_word_store #(.GROUPS(GROUPS), .GW(GW)) u_words (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (wctl),
    .rd_group  (rd_group),
    .wr_group  (grp_r),
    .wr_word   (wr_word),
    .rd_word   (rd_word),
    .busy      (busy),
    .low_group (low_group),
    .any_free  (any_free)
  );

  tbpa_count_store #(.PAGES(PAGES), .PW(PW), .COUNT_BITS(COUNT_BITS)) u_counts (
    .clk      (clk),
    .ctl      (cctl),
    .rd_page  (in_idx),
    .wr_page  (wr_page),
    .wr_count (wr_count),
    .rd_count (rd_count)
  );

  assign in_idx   = PW'(in_tdata[18:8]);
  assign addr_idx = PW'(addr_r);
  assign rd_group = (in_tuser == MODE_FREE) ? in_idx[PW-1:5] : low_group;
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid && !busy) state_nxt = S_MOD;
      S_MOD:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    fire      = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready = !busy;
      S_MOD:   fire = out_free;
      default: ;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= in_tuser;
      ucnt_r     <= in_tdata[7:0];
      addr_r     <= in_tdata[18:8];
      grp_r      <= rd_group;
      none_r     <= !any_free;
      in_range_r <= 32'(in_tdata[18:8]) < PAGES;
    end
  end

  always_comb begin
    low_bit = '0;
    for (int i = 31; i >= 0; i--) begin
      if (rd_word[i]) begin
        low_bit = 5'(i);
      end
    end
  end

  assign page_bit = rd_word[addr_r[4:0]];
  assign ucnt_eff = (ucnt_r == 8'd0) ? 8'd1 : ucnt_r;
  assign ucnt_sat = (17'(ucnt_eff) > CMAX) ? CMAX : 17'(ucnt_eff);

  always_comb begin
    wctl.rd_en = accept;
    cctl.rd_en = accept && (in_tuser == MODE_FREE);
    wctl.wr_en = 1'b0;
    cctl.wr_en = 1'b0;
    wr_word    = rd_word;
    wr_count   = COUNT_BITS'(ucnt_sat);
    wr_page    = {grp_r, low_bit};
    cnt_dec    = 1'b0;
    cnt_inc    = 1'b0;
    status     = STAT_NOTALLOC;
    page_out   = addr_r;
    if (mode_r == MODE_ALLOC) begin
      if (none_r) begin
        status   = STAT_NONE;
        page_out = '0;
      end else begin
        status     = STAT_ALLOC;
        page_out   = 11'({grp_r, low_bit});
        wr_word    = rd_word & ~(32'd1 << low_bit);
        wctl.wr_en = fire;
        cctl.wr_en = fire;
        cnt_dec    = fire;
      end
    end else if (in_range_r && !page_bit) begin
      if (rd_count > COUNT_BITS'(1)) begin
        status     = STAT_DEC;
        wr_page    = addr_idx;
        wr_count   = rd_count - COUNT_BITS'(1);
        cctl.wr_en = fire;
      end else begin
        status     = STAT_REL;
        wr_word    = rd_word | (32'd1 << addr_r[4:0]);
        wctl.wr_en = fire;
        cnt_inc    = fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNTW'(PAGES);
    end else if (cnt_dec) begin
      cnt_r <= cnt_r - CNTW'(1);
    end else if (cnt_inc) begin
      cnt_r <= cnt_r + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tdata_r <= {6'd0,
                      12'(cnt_dec ? cnt_r - CNTW'(1) : (cnt_inc ? cnt_r + CNTW'(1) : cnt_r)),
                      status, page_out};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: hdl/tbpa_checker.sv
// Port-level checker for the page allocator and its bind statement.
module tbpa_checker
  import tbpa_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Result beat changed while stalled.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input taken while a beat is still in work.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[13:11] <= STAT_NOTALLOC)
    else $error("Result status is out of range.");

  a_none_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13:11] == STAT_NONE |-> out_tdata[10:0] == 11'd0)
    else $error("Failed allocation returned a nonzero page.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Result beat shown right after reset.");

endmodule

bind two_level_bitmap_page_allocator tbpa_checker u_tbpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/tb_two_level_bitmap_page_allocator.sv
// Self-checking testbench for the two-level bitmap page allocator.
`timescale 1ns / 1ps

module tb_two_level_bitmap_page_allocator;
  import tbpa_pkg::*;

  localparam int PAGES      = 2048;
  localparam int COUNT_BITS = 8;
  localparam int GROUPS     = PAGES / 32;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [10:0] page;
    status_t     status;
    logic [11:0] free_count;
  } page_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // use_count_init[7:0], page_addr[18:8], zeros
  logic        in_tuser   = 1'b0; // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // page[10:0], status[13:11], free_count[25:14], zeros

  logic [31:0]           free_words   [GROUPS];
  logic                  group_nonempty [GROUPS];
  logic [COUNT_BITS-1:0] page_users   [PAGES];
  int                    free_left;

  page_result_t expected_results[$];
  page_result_t result_head;
  int           mismatches  = 0;
  int           rx_hold     = 0;
  int           idle_cycles = 0;
  bit           no_idle     = 1'b0;

  two_level_bitmap_page_allocator #(
    .PAGES     (PAGES),
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic bit page_in_use(input logic [10:0] p);
    return !free_words[p[10:5]][p[4:0]];
  endfunction

  task automatic predict_page_op(input mode_t m, input logic [7:0] uc,
                                 input logic [10:0] addr, output page_result_t r);
    int          g;
    int          b;
    logic [31:0] pg;
    logic [7:0]  cnt;
    g = -1;
    b = -1;
    if (free_left != 0) begin
      for (int i = 0; i < GROUPS; i++) begin
        if (g < 0 && group_nonempty[i]) g = i;
      end
    end
    if (m == MODE_ALLOC) begin
      if (g >= 0) begin
        for (int j = 0; j < 32; j++) begin
          if (b < 0 && free_words[g][j]) b = j;
        end
      end
      if (g < 0 || b < 0) begin
        r.page   = '0;
        r.status = STAT_NONE;
      end else begin
        pg = g * 32 + b;
        free_words[g][b] = 1'b0;
        if (free_words[g] == 32'h0) group_nonempty[g] = 1'b0;
        cnt = (uc == 8'd0) ? 8'd1 : uc;
        page_users[pg] = cnt;
        free_left--;
        r.page   = pg[10:0];
        r.status = STAT_ALLOC;
      end
    end else begin
      r.page = addr;
      if (addr >= PAGES) begin
        r.status = STAT_NOTALLOC;
      end else if (free_words[addr[10:5]][addr[4:0]]) begin
        r.status = STAT_NOTALLOC;
      end else if (page_users[addr] > 1) begin
        page_users[addr]--;
        r.status = STAT_DEC;
      end else begin
        free_words[addr[10:5]][addr[4:0]] = 1'b1;
        group_nonempty[addr[10:5]] = 1'b1;
        page_users[addr] = '0;
        free_left++;
        r.status = STAT_REL;
      end
    end
    pg = free_left;
    r.free_count = pg[11:0];
  endtask

  // The valid stays high after an accepted beat; the next call lowers it only for a gap.
  task automatic send_beat(input mode_t m, input logic [7:0] uc, input logic [10:0] addr);
    int           gap;
    page_result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {5'b0, addr, uc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_page_op(m, uc, addr, r);
    expected_results.push_back(r);
  endtask

  task automatic pick_used_page(output logic [10:0] p, output bit found);
    logic [10:0] start;
    logic [10:0] idx;
    start = 11'($urandom_range(0, PAGES - 1));
    found = 1'b0;
    p = '0;
    for (int k = 0; k < PAGES; k++) begin
      idx = 11'(start + k);
      if (!found && page_in_use(idx)) begin
        p = idx;
        found = 1'b1;
      end
    end
  endtask

  task automatic test_directed_cases();
    no_idle = 1'b0;
    send_beat(MODE_FREE,  8'd0,   11'd5);
    send_beat(MODE_ALLOC, 8'd0,   11'd0);
    send_beat(MODE_ALLOC, 8'd255, 11'd0);
    send_beat(MODE_ALLOC, 8'd3,   11'd2047);
    send_beat(MODE_FREE,  8'd0,   11'd0);
    send_beat(MODE_FREE,  8'd255, 11'd0);
    send_beat(MODE_ALLOC, 8'd1,   11'd2047);
    send_beat(MODE_FREE,  8'd0,   11'd1);
    send_beat(MODE_FREE,  8'd0,   11'd2);
    send_beat(MODE_FREE,  8'd0,   11'd2);
    send_beat(MODE_FREE,  8'd0,   11'd2);
    send_beat(MODE_FREE,  8'd0,   11'd2047);
    send_beat(MODE_FREE,  8'd0,   11'd1024);
    send_beat(MODE_FREE,  8'd170, 11'd1);
    send_beat(MODE_ALLOC, 8'd128, 11'd1365);
    send_beat(MODE_ALLOC, 8'd85,  11'd682);
    send_beat(MODE_FREE,  8'd0,   11'd3);
    send_beat(MODE_FREE,  8'd0,   11'd3);
    send_beat(MODE_FREE,  8'd0,   11'd0);
    send_beat(MODE_ALLOC, 8'd2,   11'd0);
  endtask

  task automatic test_fill_and_drain();
    logic [10:0] p;
    bit          found;
    int          n;
    int          base;
    base = free_left;
    n = 0;
    while (free_left > base - 120) begin
      if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_beat(MODE_ALLOC, 8'($urandom_range(0, 2)), 11'($urandom_range(0, PAGES - 1)));
      n++;
    end
    no_idle = 1'b0;
    send_beat(MODE_ALLOC, 8'd255, 11'd2047);
    send_beat(MODE_ALLOC, 8'd0,   11'd0);
    send_beat(MODE_ALLOC, 8'($urandom_range(0, 255)), 11'($urandom_range(0, PAGES - 1)));
    n = 0;
    while (free_left < base) begin
      if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        send_beat(MODE_ALLOC, 8'($urandom_range(0, 2)), 11'($urandom_range(0, PAGES - 1)));
      end else begin
        pick_used_page(p, found);
        send_beat(MODE_FREE, 8'($urandom_range(0, 255)), p);
      end
      n++;
    end
  endtask

  task automatic test_random_traffic();
    logic [10:0] p;
    bit          found;
    int          sel;
    logic [7:0]  uc;
    for (int n = 0; n < 475; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 2) == 0);
      sel = $urandom_range(0, 99);
      uc  = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
      if (sel < 45) begin
        send_beat(MODE_ALLOC, uc, 11'($urandom_range(0, PAGES - 1)));
      end else if (sel < 85) begin
        pick_used_page(p, found);
        if (!found) p = 11'($urandom_range(0, PAGES - 1));
        send_beat(MODE_FREE, uc, p);
      end else begin
        send_beat(MODE_FREE, uc, 11'($urandom_range(0, PAGES - 1)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got %h", $time, out_tdata);
        mismatches++;
      end else begin
        result_head = expected_results.pop_front();
        if (out_tdata[10:0] != result_head.page) begin
          $display("%0t: page mismatch: expected %0d, got %0d",
                   $time, result_head.page, out_tdata[10:0]);
          mismatches++;
        end
        if (out_tdata[13:11] != result_head.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, result_head.status, out_tdata[13:11]);
          mismatches++;
        end
        if (out_tdata[25:14] != result_head.free_count) begin
          $display("%0t: free_count mismatch: expected %0d, got %0d",
                   $time, result_head.free_count, out_tdata[25:14]);
          mismatches++;
        end
      end
      rx_hold = no_idle ? 0 : $urandom_range(0, 5);
    end else if (rx_hold > 0) begin
      rx_hold--;
    end
    out_tready <= (rx_hold == 0);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int g = 0; g < GROUPS; g++) begin
      free_words[g]     = 32'hffff_ffff;
      group_nonempty[g] = 1'b1;
    end
    for (int p = 0; p < PAGES; p++) page_users[p] = '0;
    free_left = PAGES;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_fill_and_drain();
    test_random_traffic();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
